// ----- sv/rgsb_pkg.sv -----
// ----------------------------------------------------------------------------
// rgsb_pkg
// Shared constants, types and arithmetic helpers of the raster grid sampler.
// ----------------------------------------------------------------------------
package rgsb_pkg;

  localparam int MAX_COLUMNS   = 256;
  localparam int MAX_ROWS      = 256;
  localparam int FRACTION_BITS = 16;

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int DIM_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int QW        = DIM_W + FRACTION_BITS;
  localparam int X_W       = 29;
  localparam int Y_W       = 28;
  localparam int D_W       = X_W;
  localparam int NUM_W     = D_W + DIM_W;
  localparam int CNT_W     = 9;
  localparam int CELL_W    = 8;
  localparam int VAL_W     = 32;
  localparam int OP_W      = 2;
  localparam int MEM_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int WGT_W     = FRACTION_BITS + 1;
  localparam int ACC_W     = VAL_W + 2 * FRACTION_BITS;
  localparam int MID_DEPTH = 4;
  localparam int MID_PW    = $clog2(MID_DEPTH);
  localparam int MID_CW    = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
  localparam logic [OP_W-1:0] OP_NEAREST  = 2'd1;
  localparam logic [OP_W-1:0] OP_BILINEAR = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_X_LOW        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_HIGH       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_LOW        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_HIGH       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 3'd5;

  localparam logic signed [X_W-1:0] X_LOW_RST  = -29'sd180000000;
  localparam logic signed [X_W-1:0] X_HIGH_RST = 29'sd180000000;
  localparam logic signed [Y_W-1:0] Y_LOW_RST  = -28'sd90000000;
  localparam logic signed [Y_W-1:0] Y_HIGH_RST = 28'sd90000000;
  localparam logic [CNT_W-1:0]      COUNT_RST  = 9'd256;
  localparam logic [CNT_W-1:0]      COUNT_MIN  = 9'd2;

  localparam logic [WGT_W-1:0] W_ONE     = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [1:0]       LAST_STEP = 2'd3;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_NEAREST,
    KIND_BILINEAR,
    KIND_NODATA
  } kind_e;

  typedef struct packed {
    logic signed [X_W-1:0] x_low;
    logic signed [X_W-1:0] x_high;
    logic signed [Y_W-1:0] y_low;
    logic signed [Y_W-1:0] y_high;
    logic [CNT_W-1:0]      column_count;
    logic [CNT_W-1:0]      row_count;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [CELL_W-1:0] cell_column;
    logic [CELL_W-1:0] cell_row;
    logic [VAL_W-1:0]  cell_value;
    logic [COL_W-1:0]  c_lim;
    logic [ROW_W-1:0]  r_lim;
  } hdr_t;

  typedef struct packed {
    hdr_t          hdr;
    logic [QW-1:0] px;
    logic [QW-1:0] py;
  } item_t;

  typedef struct packed {
    logic [D_W-1:0] span;
    logic [D_W-1:0] rem;
    logic [QW-1:0]  nb;
    logic [QW-1:0]  quo;
  } div_t;

  typedef struct packed {
    kind_e             kind;
    logic              first;
    logic              last;
    logic [WGT_W-1:0]  wx;
    logic [WGT_W-1:0]  wy;
  } tok_t;

  function automatic div_t div_init(input logic [NUM_W-1:0] num, input logic [D_W-1:0] span);
    div_t d;
    d.span = span;
    d.rem  = D_W'(num >> DIM_W);
    d.nb   = {num[DIM_W-1:0], {FRACTION_BITS{1'b0}}};
    d.quo  = '0;
    return d;
  endfunction

  function automatic div_t div_step(input div_t d);
    div_t          n;
    logic [D_W:0]  rs;
    logic [D_W:0]  rd;
    logic          qb;
    rs = {d.rem, d.nb[QW-1]};
    rd = rs - {1'b0, d.span};
    qb = (rs >= {1'b0, d.span});
    n.span = d.span;
    n.rem  = qb ? rd[D_W-1:0] : rs[D_W-1:0];
    n.nb   = {d.nb[QW-2:0], 1'b0};
    n.quo  = {d.quo[QW-2:0], qb};
    return n;
  endfunction

endpackage

// ----- sv/raster_grid_sample_bilinear.sv -----
// ----------------------------------------------------------------------------
// raster_grid_sample_bilinear
// Raster grid sampler with nearest and bilinear lookup over a loaded grid.
// ----------------------------------------------------------------------------
// A new word is taken every cycle while the back end keeps up. The back end
// drives a single-port grid memory, so a write or a nearest query makes a
// single access to it and a bilinear query four, one per neighbouring cell;
// a query outside the box makes none. The grid position of a query is formed
// in a pipelined divider. At most eight results may wait to be popped before
// queries are held back. Reading a cell that was never written returns an
// undefined sample.
module raster_grid_sample_bilinear import rgsb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [OP_W-1:0]       op_i,
  input  logic [CELL_W-1:0]     cell_column_i,
  input  logic [CELL_W-1:0]     cell_row_i,
  input  logic signed [VAL_W-1:0] cell_value_i,
  input  logic signed [X_W-1:0] longitude_i,
  input  logic signed [Y_W-1:0] latitude_i,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [VAL_W-1:0] sample_o,
  output logic                  valid_res_o
);

  cfg_t                   cfg_q;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_wr;

  logic                   fr_valid;
  item_t                  fr_item;
  logic                   mid_push, mid_pop, mid_full;
  item_t                  mid_mem_q [MID_DEPTH];
  logic [MID_PW-1:0]      mid_wp_q, mid_rp_q;
  logic [MID_CW-1:0]      mid_cnt_q;
  logic [VAL_W-1:0]       smp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_low        <= X_LOW_RST;
      cfg_q.x_high       <= X_HIGH_RST;
      cfg_q.y_low        <= Y_LOW_RST;
      cfg_q.y_high       <= Y_HIGH_RST;
      cfg_q.column_count <= COUNT_RST;
      cfg_q.row_count    <= COUNT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_X_LOW:        cfg_q.x_low        <= pwdata[X_W-1:0];
        REG_X_HIGH:       cfg_q.x_high       <= pwdata[X_W-1:0];
        REG_Y_LOW:        cfg_q.y_low        <= pwdata[Y_W-1:0];
        REG_Y_HIGH:       cfg_q.y_high       <= pwdata[Y_W-1:0];
        REG_COLUMN_COUNT: cfg_q.column_count <= pwdata[CNT_W-1:0];
        REG_ROW_COUNT:    cfg_q.row_count    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_LOW:        prdata = PDATA_W'(unsigned'(cfg_q.x_low));
      REG_X_HIGH:       prdata = PDATA_W'(unsigned'(cfg_q.x_high));
      REG_Y_LOW:        prdata = PDATA_W'(unsigned'(cfg_q.y_low));
      REG_Y_HIGH:       prdata = PDATA_W'(unsigned'(cfg_q.y_high));
      REG_COLUMN_COUNT: prdata = PDATA_W'(cfg_q.column_count);
      REG_ROW_COUNT:    prdata = PDATA_W'(cfg_q.row_count);
      default:          prdata = '0;
    endcase
  end

  rgsb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_o        (full),
    .op_i          (op_i),
    .cell_column_i (cell_column_i),
    .cell_row_i    (cell_row_i),
    .cell_value_i  (cell_value_i),
    .longitude_i   (longitude_i),
    .latitude_i    (latitude_i),
    .mid_full_i    (mid_full),
    .item_valid_o  (fr_valid),
    .item_o        (fr_item)
  );

  assign mid_full = (mid_cnt_q == MID_CW'(MID_DEPTH));
  assign mid_push = fr_valid && !mid_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_wp_q  <= '0;
      mid_rp_q  <= '0;
      mid_cnt_q <= '0;
    end else begin
      if (mid_push) begin
        mid_wp_q <= mid_wp_q + 1'b1;
      end
      if (mid_pop) begin
        mid_rp_q <= mid_rp_q + 1'b1;
      end
      mid_cnt_q <= mid_cnt_q + MID_CW'(mid_push) - MID_CW'(mid_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_push) begin
      mid_mem_q[mid_wp_q] <= fr_item;
    end
  end

  rgsb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (mid_cnt_q != '0),
    .item_i       (mid_mem_q[mid_rp_q]),
    .item_pop_o   (mid_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .sample_o     (smp),
    .valid_res_o  (valid_res_o)
  );

  assign sample_o = smp;

  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> !mid_full)
    else $error("word pushed into a full mid queue");

  a_mid_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> mid_cnt_q != '0)
    else $error("word taken from an empty mid queue");

  a_mid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> mid_cnt_q == $past(mid_cnt_q) + MID_CW'($past(mid_push))
                          - MID_CW'($past(mid_pop)))
    else $error("mid queue fill level lost track of words");

endmodule

// ----- sv/rgsb_front.sv -----
// ----------------------------------------------------------------------------
// rgsb_front
// Takes input words, checks the point against the box and maps it to a
// fixed-point grid position through a pipelined restoring divider.
// ----------------------------------------------------------------------------
module rgsb_front import rgsb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic [CELL_W-1:0]        cell_column_i,
  input  logic [CELL_W-1:0]        cell_row_i,
  input  logic [VAL_W-1:0]         cell_value_i,
  input  logic signed [X_W-1:0]    longitude_i,
  input  logic signed [Y_W-1:0]    latitude_i,
  input  logic                     mid_full_i,
  output logic                     item_valid_o,
  output item_t                    item_o
);

  logic                  adv;
  logic                  s1_v_q;
  logic [OP_W-1:0]       s1_op_q;
  logic [CELL_W-1:0]     s1_col_q;
  logic [CELL_W-1:0]     s1_row_q;
  logic [VAL_W-1:0]      s1_val_q;
  logic signed [X_W-1:0] s1_lon_q;
  logic signed [Y_W-1:0] s1_lat_q;

  logic signed [D_W:0]   dxw;
  logic signed [D_W:0]   spxw;
  logic signed [D_W:0]   dyw;
  logic signed [D_W:0]   spyw;
  logic                  box_ok;
  hdr_t                  s2_hdr_d;

  logic                  s2_v_q;
  hdr_t                  s2_hdr_q;
  logic [D_W-1:0]        s2_dx_q;
  logic [D_W-1:0]        s2_dy_q;
  logic [D_W-1:0]        s2_spx_q;
  logic [D_W-1:0]        s2_spy_q;

  logic                  s3_v_q;
  hdr_t                  s3_hdr_q;
  logic [NUM_W-1:0]      s3_numx_q;
  logic [NUM_W-1:0]      s3_numy_q;
  logic [D_W-1:0]        s3_spx_q;
  logic [D_W-1:0]        s3_spy_q;

  logic [QW-1:0]         dv_q;
  hdr_t                  dh_q  [QW];
  div_t                  dxs_q [QW];
  div_t                  dys_q [QW];

  assign adv    = !(dv_q[QW-1] && mid_full_i);
  assign full_o = !adv;

  always_comb begin
    dxw  = (D_W+1)'(s1_lon_q) - (D_W+1)'(cfg_i.x_low);
    spxw = (D_W+1)'(cfg_i.x_high) - (D_W+1)'(cfg_i.x_low);
    dyw  = (D_W+1)'(cfg_i.y_high) - (D_W+1)'(s1_lat_q);
    spyw = (D_W+1)'(cfg_i.y_high) - (D_W+1)'(cfg_i.y_low);
    box_ok = (cfg_i.x_high > cfg_i.x_low) && (cfg_i.y_high > cfg_i.y_low) &&
             (cfg_i.column_count >= COUNT_MIN) && (cfg_i.row_count >= COUNT_MIN) &&
             (s1_lon_q >= cfg_i.x_low) && (s1_lon_q <= cfg_i.x_high) &&
             (s1_lat_q >= cfg_i.y_low) && (s1_lat_q <= cfg_i.y_high);
    s2_hdr_d.cell_column = s1_col_q;
    s2_hdr_d.cell_row    = s1_row_q;
    s2_hdr_d.cell_value  = s1_val_q;
    s2_hdr_d.c_lim = (int'(cfg_i.column_count) > MAX_COLUMNS) ? COL_W'(MAX_COLUMNS - 1) :
                     COL_W'(cfg_i.column_count - 1'b1);
    s2_hdr_d.r_lim = (int'(cfg_i.row_count) > MAX_ROWS) ? ROW_W'(MAX_ROWS - 1) :
                     ROW_W'(cfg_i.row_count - 1'b1);
    case (s1_op_q)
      OP_WRITE:    s2_hdr_d.kind = KIND_WRITE;
      OP_NEAREST:  s2_hdr_d.kind = box_ok ? KIND_NEAREST : KIND_NODATA;
      OP_BILINEAR: s2_hdr_d.kind = box_ok ? KIND_BILINEAR : KIND_NODATA;
      default:     s2_hdr_d.kind = KIND_NODATA;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      dv_q   <= '0;
    end else if (adv) begin
      s1_v_q <= push_i;
      s2_v_q <= s1_v_q && (s1_op_q == OP_WRITE || s1_op_q == OP_NEAREST ||
                           s1_op_q == OP_BILINEAR);
      s3_v_q <= s2_v_q;
      dv_q   <= {dv_q[QW-2:0], s3_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q   <= op_i;
      s1_col_q  <= cell_column_i;
      s1_row_q  <= cell_row_i;
      s1_val_q  <= cell_value_i;
      s1_lon_q  <= longitude_i;
      s1_lat_q  <= latitude_i;
      s2_hdr_q  <= s2_hdr_d;
      s2_dx_q   <= dxw[D_W-1:0];
      s2_dy_q   <= dyw[D_W-1:0];
      s2_spx_q  <= spxw[D_W-1:0];
      s2_spy_q  <= spyw[D_W-1:0];
      s3_hdr_q  <= s2_hdr_q;
      s3_numx_q <= NUM_W'(s2_dx_q) * NUM_W'(s2_hdr_q.c_lim);
      s3_numy_q <= NUM_W'(s2_dy_q) * NUM_W'(s2_hdr_q.r_lim);
      s3_spx_q  <= s2_spx_q;
      s3_spy_q  <= s2_spy_q;
      dh_q[0]   <= s3_hdr_q;
      dxs_q[0]  <= div_step(div_init(s3_numx_q, s3_spx_q));
      dys_q[0]  <= div_step(div_init(s3_numy_q, s3_spy_q));
      for (int k = 1; k < QW; k++) begin
        dh_q[k]  <= dh_q[k-1];
        dxs_q[k] <= div_step(dxs_q[k-1]);
        dys_q[k] <= div_step(dys_q[k-1]);
      end
    end
  end

  assign item_valid_o = dv_q[QW-1];
  assign item_o.hdr   = dh_q[QW-1];
  assign item_o.px    = dxs_q[QW-1].quo;
  assign item_o.py    = dys_q[QW-1].quo;

endmodule

// ----- sv/rgsb_back.sv -----
// ----------------------------------------------------------------------------
// rgsb_back
// Owns the grid memory, steps through the cell accesses of each word, weights
// the samples and queues the results.
// ----------------------------------------------------------------------------
module rgsb_back import rgsb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              item_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [VAL_W-1:0]  sample_o,
  output logic              valid_res_o
);

  logic                     cur_v_q;
  kind_e                    cur_kind_q;
  logic [1:0]               step_q;
  logic [COL_W-1:0]         c0_q, c1_q;
  logic [ROW_W-1:0]         r0_q, r1_q;
  logic [FRACTION_BITS-1:0] fx_q, fy_q;
  logic [VAL_W-1:0]         val_q;
  logic                     wr_ok_q;

  logic [COL_W-1:0]         c0_d, c1_d;
  logic [ROW_W-1:0]         r0_d, r1_d;
  logic [QW:0]              rxn, ryn;
  logic [DIM_W:0]           cn, rn;
  logic [DIM_W-1:0]         cb, rb;
  logic                     step_last, can_take, credit_ok, take;
  logic [COL_W-1:0]         sel_c;
  logic [ROW_W-1:0]         sel_r;
  logic [ADDR_W-1:0]        addr;
  logic                     mem_we, mem_re;
  tok_t                     tok_d;

  logic [VAL_W-1:0]         mem [MEM_DEPTH];
  logic [VAL_W-1:0]         rd_q;
  logic                     t1_v_q, t2_v_q, t3_v_q;
  tok_t                     t1_q, t2_q, t3_q;
  logic [VAL_W-1:0]         d2_q, d3_q;
  logic [VAL_W+WGT_W-1:0]   p1_q;
  logic [ACC_W-1:0]         p2_q;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [VAL_W-1:0]         quo;
  logic                     inexact;
  logic                     res_push;
  logic [VAL_W-1:0]         res_sample;
  logic                     res_valid;

  logic [OUT_CW-1:0]        oc_q;
  logic [VAL_W-1:0]         ofs_q [OUT_DEPTH];
  logic                     ofv_q [OUT_DEPTH];
  logic [OUT_PW-1:0]        owp_q, orp_q;
  logic [OUT_CW-1:0]        ocnt_q;
  logic                     out_pop;

  always_comb begin
    rxn = {1'b0, item_i.px} + (QW+1)'(W_ONE >> 1);
    ryn = {1'b0, item_i.py} + (QW+1)'(W_ONE >> 1);
    cn  = rxn[QW:FRACTION_BITS];
    rn  = ryn[QW:FRACTION_BITS];
    cb  = item_i.px[QW-1:FRACTION_BITS];
    rb  = item_i.py[QW-1:FRACTION_BITS];
    c1_d = '0;
    r1_d = '0;
    case (item_i.hdr.kind)
      KIND_WRITE: begin
        c0_d = COL_W'(item_i.hdr.cell_column);
        r0_d = ROW_W'(item_i.hdr.cell_row);
      end
      KIND_NEAREST: begin
        c0_d = (cn > (DIM_W+1)'(item_i.hdr.c_lim)) ? item_i.hdr.c_lim : COL_W'(cn);
        r0_d = (rn > (DIM_W+1)'(item_i.hdr.r_lim)) ? item_i.hdr.r_lim : ROW_W'(rn);
      end
      default: begin
        c0_d = (cb > DIM_W'(item_i.hdr.c_lim)) ? item_i.hdr.c_lim : COL_W'(cb);
        r0_d = (rb > DIM_W'(item_i.hdr.r_lim)) ? item_i.hdr.r_lim : ROW_W'(rb);
      end
    endcase
    c1_d = (c0_d == item_i.hdr.c_lim) ? c0_d : c0_d + 1'b1;
    r1_d = (r0_d == item_i.hdr.r_lim) ? r0_d : r0_d + 1'b1;
  end

  assign step_last  = (cur_kind_q != KIND_BILINEAR) || (step_q == LAST_STEP);
  assign can_take   = !cur_v_q || step_last;
  assign credit_ok  = (oc_q < OUT_CW'(OUT_DEPTH));
  assign take       = item_valid_i && can_take &&
                      (item_i.hdr.kind == KIND_WRITE || credit_ok);
  assign item_pop_o = take;

  always_comb begin
    sel_c = (cur_kind_q == KIND_BILINEAR && step_q[0]) ? c1_q : c0_q;
    sel_r = (cur_kind_q == KIND_BILINEAR && step_q[1]) ? r1_q : r0_q;
    addr  = ADDR_W'(sel_r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(sel_c);
    mem_we = cur_v_q && cur_kind_q == KIND_WRITE && wr_ok_q;
    mem_re = cur_v_q && (cur_kind_q == KIND_NEAREST || cur_kind_q == KIND_BILINEAR);
    tok_d.kind  = cur_kind_q;
    tok_d.first = (step_q == 2'd0);
    tok_d.last  = step_last;
    tok_d.wx    = step_q[0] ? {1'b0, fx_q} : W_ONE - {1'b0, fx_q};
    tok_d.wy    = step_q[1] ? {1'b0, fy_q} : W_ONE - {1'b0, fy_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      step_q  <= '0;
      t1_v_q  <= 1'b0;
      t2_v_q  <= 1'b0;
      t3_v_q  <= 1'b0;
      oc_q    <= '0;
    end else begin
      if (take) begin
        cur_v_q <= 1'b1;
        step_q  <= '0;
      end else if (cur_v_q && step_last) begin
        cur_v_q <= 1'b0;
      end else if (cur_v_q) begin
        step_q <= step_q + 1'b1;
      end
      t1_v_q <= cur_v_q && cur_kind_q != KIND_WRITE;
      t2_v_q <= t1_v_q;
      t3_v_q <= t2_v_q;
      oc_q   <= oc_q + OUT_CW'(take && item_i.hdr.kind != KIND_WRITE) - OUT_CW'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_kind_q <= item_i.hdr.kind;
      c0_q       <= c0_d;
      c1_q       <= c1_d;
      r0_q       <= r0_d;
      r1_q       <= r1_d;
      fx_q       <= item_i.px[FRACTION_BITS-1:0];
      fy_q       <= item_i.py[FRACTION_BITS-1:0];
      val_q      <= item_i.hdr.cell_value;
      wr_ok_q    <= (int'(item_i.hdr.cell_column) < MAX_COLUMNS) &&
                    (int'(item_i.hdr.cell_row) < MAX_ROWS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= val_q;
    end
    if (mem_re) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= tok_d;
    t2_q  <= t1_q;
    d2_q  <= rd_q;
    p1_q  <= (VAL_W+WGT_W)'({~rd_q[VAL_W-1], rd_q[VAL_W-2:0]}) * (VAL_W+WGT_W)'(t1_q.wx);
    t3_q  <= t2_q;
    d3_q  <= d2_q;
    p2_q  <= ACC_W'(p1_q) * ACC_W'(t2_q.wy);
    if (t3_v_q) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    acc_d   = (t3_q.first ? '0 : acc_q) + p2_q;
    quo     = acc_d[ACC_W-1:2*FRACTION_BITS];
    inexact = |acc_d[2*FRACTION_BITS-1:0];
    res_push = t3_v_q && t3_q.last;
    case (t3_q.kind)
      KIND_NEAREST: begin
        res_sample = d3_q;
        res_valid  = 1'b1;
      end
      KIND_BILINEAR: begin
        res_sample = {~quo[VAL_W-1], quo[VAL_W-2:0]} +
                     VAL_W'(~quo[VAL_W-1] & inexact);
        res_valid  = 1'b1;
      end
      default: begin
        res_sample = '0;
        res_valid  = 1'b0;
      end
    endcase
  end

  assign out_pop = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (res_push) begin
        owp_q <= owp_q + 1'b1;
      end
      if (out_pop) begin
        orp_q <= orp_q + 1'b1;
      end
      ocnt_q <= ocnt_q + OUT_CW'(res_push) - OUT_CW'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      ofs_q[owp_q] <= res_sample;
      ofv_q[owp_q] <= res_valid;
    end
  end

  assign empty_o     = (ocnt_q == '0);
  assign sample_o    = ofs_q[orp_q];
  assign valid_res_o = ofv_q[orp_q];

endmodule

// ----- tb/raster_grid_sample_bilinear_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// raster_grid_sample_bilinear_tb
// Self-checking bench for the raster grid sampler. A generator loads grid
// cells and issues nearest and bilinear queries under several box and size
// settings. It predicts every result in fixed point and compares each popped
// word with the oldest prediction. Both sides idle at random, and the result
// side holds off once for long enough to fill the block.
// ----------------------------------------------------------------------------
module raster_grid_sample_bilinear_tb;
  import rgsb_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CELL_W-1:0] col;
    logic [CELL_W-1:0] row;
    logic [VAL_W-1:0]  val;
    logic [X_W-1:0]    lon;
    logic [Y_W-1:0]    lat;
  } word_t;

  typedef struct {
    logic [VAL_W-1:0] sample;
    logic             valid;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic push = 1'b0, pop = 1'b0;
  logic full, empty;
  logic [OP_W-1:0] op_i = '0;
  logic [CELL_W-1:0] cell_column_i = '0, cell_row_i = '0;
  logic signed [VAL_W-1:0] cell_value_i = '0;
  logic signed [X_W-1:0] longitude_i = '0;
  logic signed [Y_W-1:0] latitude_i = '0;
  logic signed [VAL_W-1:0] sample_o;
  logic valid_res_o;

  raster_grid_sample_bilinear dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .op_i, .cell_column_i, .cell_row_i, .cell_value_i,
    .longitude_i, .latitude_i, .empty, .pop, .sample_o, .valid_res_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  word_t   pending_words[$];
  lookup_t expected_lookups[$];
  logic [VAL_W-1:0] grid_mem[MEM_DEPTH];
  bit grid_written[MEM_DEPTH];
  logic signed [X_W-1:0] box_x_low = X_LOW_RST, box_x_high = X_HIGH_RST;
  logic signed [Y_W-1:0] box_y_low = Y_LOW_RST, box_y_high = Y_HIGH_RST;
  logic [CNT_W-1:0] grid_cols = COUNT_RST, grid_rows = COUNT_RST;
  int errors = 0, words_sent = 0, lookups_checked = 0, stall_count = 0;
  bit steady = 1'b0, hold_request = 1'b0;
  int hold_left = 0;

  // Works out which cells a query reads and the fractional weights.
  function automatic bit locate(input logic [OP_W-1:0] op, input logic [X_W-1:0] lon_w,
                                input logic [Y_W-1:0] lat_w, output int c0, output int c1,
                                output int r0, output int r1, output longint fx,
                                output longint fy);
    longint xl, xh, yl, yh, lon, lat, cols, rows, px, py, num;
    xl = longint'(box_x_low); xh = longint'(box_x_high);
    yl = longint'(box_y_low); yh = longint'(box_y_high);
    lon = longint'($signed(lon_w)); lat = longint'($signed(lat_w));
    cols = grid_cols > MAX_COLUMNS ? MAX_COLUMNS : grid_cols;
    rows = grid_rows > MAX_ROWS ? MAX_ROWS : grid_rows;
    c0 = 0; c1 = 0; r0 = 0; r1 = 0; fx = 0; fy = 0;
    if (xh <= xl || yh <= yl || cols < 2 || rows < 2) return 1'b0;
    if (lon < xl || lon > xh || lat < yl || lat > yh) return 1'b0;
    num = (lon - xl) * (cols - 1);
    px = ((num / (xh - xl)) << FRACTION_BITS) | (((num % (xh - xl)) << FRACTION_BITS) / (xh - xl));
    num = (yh - lat) * (rows - 1);
    py = ((num / (yh - yl)) << FRACTION_BITS) | (((num % (yh - yl)) << FRACTION_BITS) / (yh - yl));
    if (op == OP_NEAREST) begin
      px = px + (1 << (FRACTION_BITS - 1));
      py = py + (1 << (FRACTION_BITS - 1));
    end else begin
      fx = px & ((1 << FRACTION_BITS) - 1);
      fy = py & ((1 << FRACTION_BITS) - 1);
    end
    c0 = int'(px >> FRACTION_BITS); r0 = int'(py >> FRACTION_BITS);
    if (c0 > cols - 1) c0 = int'(cols - 1);
    if (r0 > rows - 1) r0 = int'(rows - 1);
    c1 = (c0 + 1 > cols - 1) ? int'(cols - 1) : c0 + 1;
    r1 = (r0 + 1 > rows - 1) ? int'(rows - 1) : r0 + 1;
    return 1'b1;
  endfunction

  function automatic lookup_t blend(input logic [OP_W-1:0] op, input int c0, input int c1,
                                    input int r0, input int r1, input longint fx,
                                    input longint fy);
    lookup_t res;
    longint unsigned u[4], w[4], hi, lo, t, one, fmask;
    longint s;
    res.valid = 1'b1;
    if (op == OP_NEAREST) begin
      res.sample = grid_mem[r0 * MAX_COLUMNS + c0];
      return res;
    end
    one = 64'd1 << FRACTION_BITS;
    fmask = one - 1;
    u[0] = {32'd0, grid_mem[r0 * MAX_COLUMNS + c0] ^ 32'h8000_0000};
    u[1] = {32'd0, grid_mem[r0 * MAX_COLUMNS + c1] ^ 32'h8000_0000};
    u[2] = {32'd0, grid_mem[r1 * MAX_COLUMNS + c0] ^ 32'h8000_0000};
    u[3] = {32'd0, grid_mem[r1 * MAX_COLUMNS + c1] ^ 32'h8000_0000};
    w[0] = (one - fx) * (one - fy);
    w[1] = fx * (one - fy);
    w[2] = (one - fx) * fy;
    w[3] = fx * fy;
    hi = 0; lo = 0;
    for (int i = 0; i < 4; i++) begin
      hi += u[i] * (w[i] >> FRACTION_BITS);
      lo += u[i] * (w[i] & fmask);
    end
    t = hi + (lo >> FRACTION_BITS);
    s = longint'(t >> FRACTION_BITS) - 64'sd2147483648;
    if (s < 0 && (((lo & fmask) != 0) || ((t & fmask) != 0))) s += 1;
    res.sample = s[31:0];
    return res;
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input int col, input int row,
                           input int val, input int lon, input int lat);
    word_t w;
    w = '{op, CELL_W'(col), CELL_W'(row), VAL_W'(val), X_W'(lon), Y_W'(lat)};
    pending_words = {pending_words, w};
    if (op == OP_WRITE) begin
      grid_mem[w.row * MAX_COLUMNS + w.col] = w.val;
      grid_written[w.row * MAX_COLUMNS + w.col] = 1'b1;
    end
  endtask

  // A query's cells that are still blank are loaded just before it.
  task automatic send_query(input logic [OP_W-1:0] op, input int lon, input int lat);
    int c[2], r[2];
    longint fx, fy;
    lookup_t res;
    if (locate(op, X_W'(lon), Y_W'(lat), c[0], c[1], r[0], r[1], fx, fy)) begin
      foreach (c[i]) foreach (r[j])
        if (!grid_written[r[j] * MAX_COLUMNS + c[i]])
          send_word(OP_WRITE, c[i], r[j], $urandom, $urandom, $urandom);
      res = blend(op, c[0], c[1], r[0], r[1], fx, fy);
    end else begin
      res = '{'0, 1'b0};
    end
    send_word(op, $urandom, $urandom, $urandom, lon, lat);
    expected_lookups = {expected_lookups, res};
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_X_LOW:        box_x_low = value[X_W-1:0];
      REG_X_HIGH:       box_x_high = value[X_W-1:0];
      REG_Y_LOW:        box_y_low = value[Y_W-1:0];
      REG_Y_HIGH:       box_y_high = value[Y_W-1:0];
      REG_COLUMN_COUNT: grid_cols = value[CNT_W-1:0];
      REG_ROW_COUNT:    grid_rows = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int xl, input int xh, input int yl, input int yh,
                          input int cols, input int rows);
    reg_write(REG_X_LOW, xl);
    reg_write(REG_X_HIGH, xh);
    reg_write(REG_Y_LOW, yl);
    reg_write(REG_Y_HIGH, yh);
    reg_write(REG_COLUMN_COUNT, cols);
    reg_write(REG_ROW_COUNT, rows);
  endtask

  task automatic drain;
    while (pending_words.size() != 0 || expected_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_coord(input int lo, input int hi, input int limit);
    int sel;
    sel = $urandom_range(99);
    if (hi > lo && sel < 75) return lo + int'($urandom_range(hi - lo, 0));
    if (sel < 82) return lo;
    if (sel < 89) return hi;
    return int'($urandom_range(2 * limit, 0)) - limit;
  endfunction

  task automatic random_words(input int n);
    int sel;
    logic [OP_W-1:0] op;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        send_word(OP_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 20) begin
        send_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        op = (sel < 60) ? OP_NEAREST : OP_BILINEAR;
        send_query(op, pick_coord(int'(box_x_low), int'(box_x_high), 180000000),
                   pick_coord(int'(box_y_low), int'(box_y_high), 90000000));
      end
    end
  endtask

  always @(posedge clk_i) begin
    word_t w;
    bit accepted;
    accepted = push && !full;
    if (accepted) begin
      void'(pending_words.pop_front());
      words_sent++;
    end
    if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
      w = pending_words[0];
      push <= 1'b1;
      op_i <= w.op; cell_column_i <= w.col; cell_row_i <= w.row;
      cell_value_i <= w.val; longitude_i <= w.lon; latitude_i <= w.lat;
    end else begin
      push <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    lookup_t exp_res;
    if (pop && !empty) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected word: sample %0d valid %0b", $time, sample_o, valid_res_o);
        errors++;
      end else begin
        exp_res = expected_lookups.pop_front();
        lookups_checked++;
        if (sample_o !== exp_res.sample) begin
          $display("%0t: sample: expected %0d, actual %0d", $time,
                   $signed(exp_res.sample), sample_o);
          errors++;
        end
        if (valid_res_o !== exp_res.valid) begin
          $display("%0t: valid_res: expected %0b, actual %0b", $time,
                   exp_res.valid, valid_res_o);
          errors++;
        end
      end
    end
    if (hold_request && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_request = 1'b0;
      pop <= 1'b0;
    end else begin
      pop <= steady || $urandom_range(99) >= 23;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) stall_count = 0;
    else stall_count++;
    if (stall_count >= STALL_LIMIT) begin
      $display("raster_grid_sample_bilinear: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default box with the whole world and the full grid.
    send_word(OP_WRITE, 0, 0, 32'h8000_0000, 0, 0);
    send_word(OP_WRITE, 255, 255, 32'h7fff_ffff, -1, -1);
    send_word(OP_UNUSED, 8'hff, 8'hff, 32'hffff_ffff, -1, -1);
    send_query(OP_NEAREST, -180000000, 90000000);
    send_query(OP_BILINEAR, 180000000, -90000000);
    send_query(OP_BILINEAR, 0, 0);
    send_query(OP_NEAREST, 180000000, 0);
    send_query(OP_BILINEAR, -180000000, -90000000);
    send_query(OP_NEAREST, -180000000, 0);
    send_query(OP_BILINEAR, 179999999, 89999999);
    random_words(40);
    drain();

    // Smallest grid; the first stretch runs without idling.
    set_grid(-1000, 1000, -500, 500, 2, 2);
    steady = 1'b1;
    send_word(OP_WRITE, 0, 0, 32'h7fff_ffff, 0, 0);
    send_word(OP_WRITE, 1, 0, 32'h8000_0000, 0, 0);
    send_word(OP_WRITE, 0, 1, 32'h8000_0000, 0, 0);
    send_word(OP_WRITE, 1, 1, 32'h7fff_ffff, 0, 0);
    send_query(OP_BILINEAR, 1, 1);
    send_query(OP_BILINEAR, -1, 3);
    send_query(OP_NEAREST, 1001, 0);
    send_query(OP_BILINEAR, 0, -501);
    random_words(120);
    drain();
    steady = 1'b0;

    // Odd sizes, with the result side held off to fill the block.
    set_grid(-2000000, 3500000, 100000, 900000, 5, 7);
    hold_request = 1'b1;
    random_words(130);
    drain();

    set_grid(-180000000, 180000000, -90000000, 90000000, 256, 2);
    random_words(40);
    drain();

    // Counts past the grid saturate.
    set_grid(-7, 7, -3, 3, 300, 511);
    random_words(40);
    drain();

    // Boxes and counts that contain no point.
    set_grid(500, -500, 0, 0, 4, 4);
    random_words(30);
    drain();
    set_grid(-1000, 1000, -1000, 1000, 1, 4);
    random_words(20);
    drain();
    set_grid(-1000, 1000, -1000, 1000, 4, 0);
    random_words(20);
    drain();

    $display("Sent %0d words over eight grid settings and checked %0d lookups.",
             words_sent, lookups_checked);
    if (errors == 0) begin
      $display("raster_grid_sample_bilinear: match");
    end else begin
      $display("raster_grid_sample_bilinear: mismatch");
    end
    $finish;
  end

endmodule

// ----- raster_grid_sample_bilinear.f -----
sv/rgsb_pkg.sv
sv/rgsb_front.sv
sv/rgsb_back.sv
sv/raster_grid_sample_bilinear.sv
tb/raster_grid_sample_bilinear_tb.sv
